// ===== hw/rtl/sglm_pkg.sv =====
// ----------------------------------------------------------------------------
// sglm_pkg
// Shared types and codes for the sequence gap loss monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package sglm_pkg;

  localparam logic [1:0] ST_IN_ORDER = 2'd0;
  localparam logic [1:0] ST_GAP      = 2'd1;
  localparam logic [1:0] ST_OWN      = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_HIST  = 4'b1000
  } sglm_state_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic look;
    logic hist;
  } sglm_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_busy;
  } sglm_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sglm_ram.sv =====
// ----------------------------------------------------------------------------
// sglm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sglm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sglm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sglm_ctrl
// Controller: sequences the clearing pass and the two-step table update.
// ----------------------------------------------------------------------------
`default_nettype none

module sglm_ctrl
  import sglm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire sglm_stat_t stat,
  output sglm_cmd_t       cmd
);

  sglm_state_t state;
  sglm_state_t state_next;
  logic        take;

  assign in_ready = ((state == S_IDLE) || (state == S_HIST)) && !stat.out_busy;
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd.clear = (state == S_CLEAR);
    cmd.take  = take;
    cmd.look  = (state == S_LOOK);
    cmd.hist  = (state == S_HIST);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_HIST;
      end
      S_HIST: begin
        state_next = take ? S_LOOK : S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sglm_dp.sv =====
// ----------------------------------------------------------------------------
// sglm_dp
// Datapath: per-sender tables, gap arithmetic, histogram and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sglm_dp
  import sglm_pkg::*;
#(
  parameter int NUM_SENDERS = 8,
  parameter int HIST_BINS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sglm_cmd_t   cmd,
  output sglm_stat_t       stat,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic [7:0]  sender,
  input  wire logic [31:0] frame_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic signed [31:0] gap_size,
  output logic signed [31:0] lost_so_far,
  output logic [31:0]      received_so_far,
  output logic [3:0]       bin_hit
);

  localparam int HIST_DEPTH = NUM_SENDERS * HIST_BINS;
  localparam int SW         = $clog2(NUM_SENDERS);
  localparam int BW         = $clog2(HIST_BINS);
  localparam int HAW        = $clog2(HIST_DEPTH);

  logic [7:0]     own_number;
  logic [SW-1:0]  snd_q;
  logic [31:0]    fc_q;
  logic           own_q;
  logic           bad_q;
  logic           upd_q;
  logic [HAW-1:0] hist_addr_q;

  logic [HAW-1:0] clr_addr;
  logic [SW-1:0]  clr_snd;
  logic [BW-1:0]  clr_bin;

  logic [31:0]    last_rd;
  logic [31:0]    lost_rd;
  logic [31:0]    recv_rd;
  logic [31:0]    hist_rd;

  logic           resync;
  logic [31:0]    gap;
  logic           gap_zero;
  logic [31:0]    mag;
  logic [31:0]    bin32;
  logic [31:0]    lost_new;
  logic [31:0]    recv_new;
  logic [HAW-1:0] hist_addr;

  logic           tbl_we;
  logic [SW-1:0]  tbl_waddr;
  logic [31:0]    last_wdata;
  logic [31:0]    lost_wdata;
  logic [31:0]    recv_wdata;
  logic           hist_we;
  logic [HAW-1:0] hist_waddr;
  logic [31:0]    hist_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_number <= 8'hFF;
    end else if (cfg_we) begin
      own_number <= cfg_wdata;
    end
  end

  // Clearing pass walks the histogram and rewrites the sender tables on the way.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_snd  <= '0;
      clr_bin  <= '0;
    end else if (cmd.clear && !stat.clr_done) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_bin == BW'(HIST_BINS - 1)) begin
        clr_bin <= '0;
        clr_snd <= clr_snd + 1'b1;
      end else begin
        clr_bin <= clr_bin + 1'b1;
      end
    end
  end

  always_comb begin
    stat.clr_done = (clr_addr == HAW'(HIST_DEPTH - 1));
    stat.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_q <= 1'b0;
    end else if (cmd.take) begin
      upd_q <= (sender != own_number) && ({1'b0, sender} < 9'(NUM_SENDERS));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      snd_q <= sender[SW-1:0];
      fc_q  <= frame_count;
      own_q <= (sender == own_number);
      bad_q <= ({1'b0, sender} >= 9'(NUM_SENDERS));
    end
    if (cmd.look) begin
      hist_addr_q <= hist_addr;
    end
  end

  always_comb begin
    resync   = (last_rd == 32'd0) || (fc_q < last_rd);
    gap      = resync ? 32'd0 : (fc_q + ~last_rd);
    gap_zero = (gap == 32'd0);
    mag      = gap[31] ? (32'd0 - gap) : gap;
    bin32    = gap_zero ? 32'd0 :
               ((mag > 32'(HIST_BINS - 1)) ? 32'(HIST_BINS - 1) : mag);
    lost_new = gap_zero ? lost_rd : (lost_rd + gap);
    recv_new = gap_zero ? (recv_rd + 32'd1) : recv_rd;
    hist_addr = HAW'(snd_q) * HAW'(HIST_BINS) + HAW'(bin32[BW-1:0]);
  end

  always_comb begin
    tbl_we     = cmd.clear || (cmd.look && upd_q);
    tbl_waddr  = cmd.clear ? clr_snd : snd_q;
    last_wdata = cmd.clear ? 32'd0 : fc_q;
    lost_wdata = cmd.clear ? 32'd0 : lost_new;
    recv_wdata = cmd.clear ? 32'd0 : recv_new;
    hist_we    = cmd.clear || (cmd.hist && upd_q);
    hist_waddr = cmd.clear ? clr_addr : hist_addr_q;
    hist_wdata = cmd.clear ? 32'd0 : (hist_rd + 32'd1);
  end

  sglm_ram #(.WIDTH(32), .DEPTH(NUM_SENDERS)) u_last (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(last_wdata),
    .re(cmd.take), .raddr(sender[SW-1:0]), .rdata(last_rd)
  );

  sglm_ram #(.WIDTH(32), .DEPTH(NUM_SENDERS)) u_lost (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(lost_wdata),
    .re(cmd.take), .raddr(sender[SW-1:0]), .rdata(lost_rd)
  );

  sglm_ram #(.WIDTH(32), .DEPTH(NUM_SENDERS)) u_recv (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(recv_wdata),
    .re(cmd.take), .raddr(sender[SW-1:0]), .rdata(recv_rd)
  );

  sglm_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .re(cmd.look), .raddr(hist_addr), .rdata(hist_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.look) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      if (own_q) begin
        status          <= ST_OWN;
        gap_size        <= '0;
        lost_so_far     <= '0;
        received_so_far <= '0;
        bin_hit         <= '0;
      end else if (bad_q) begin
        status          <= ST_BAD;
        gap_size        <= '0;
        lost_so_far     <= '0;
        received_so_far <= '0;
        bin_hit         <= '0;
      end else begin
        status          <= gap_zero ? ST_IN_ORDER : ST_GAP;
        gap_size        <= gap;
        lost_so_far     <= lost_new;
        received_so_far <= recv_new;
        bin_hit         <= bin32[3:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sequence_gap_loss_monitor.sv =====
// ----------------------------------------------------------------------------
// sequence_gap_loss_monitor
// Per-sender frame loss statistics from frame header sequence counters.
// ----------------------------------------------------------------------------
// Each item is one frame header and gives one result. Items are handled in
// two steps, the read of the sender tables followed by the read-modify-write
// of the gap histogram memory; the next item can be accepted during the
// histogram step unless the result side is stalled. After reset the block runs
// a clearing pass over the whole histogram before it accepts the first item.
`default_nettype none

module sequence_gap_loss_monitor
  import sglm_pkg::*;
#(
  parameter int NUM_SENDERS = 8,
  parameter int HIST_BINS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  sender,
  input  wire logic [31:0] frame_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic signed [31:0] gap_size,
  output logic signed [31:0] lost_so_far,
  output logic [31:0]      received_so_far,
  output logic [3:0]       bin_hit
);

  sglm_cmd_t  cmd;
  sglm_stat_t stat;

  sglm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sglm_dp #(
    .NUM_SENDERS (NUM_SENDERS),
    .HIST_BINS   (HIST_BINS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .sender          (sender),
    .frame_count     (frame_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .gap_size        (gap_size),
    .lost_so_far     (lost_so_far),
    .received_so_far (received_so_far),
    .bin_hit         (bin_hit)
  );

endmodule

`default_nettype wire

// ===== tb/sglm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sglm_checker
// Watches both channels of the sequence gap loss monitor, keeps its own copy
// of the per-sender loss tables, predicts the result of every accepted frame
// header and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module sglm_checker
  import sglm_pkg::*;
#(
  parameter int NUM_SENDERS = 8,
  parameter int HIST_BINS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         sender,
  input  logic [31:0]        frame_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic signed [31:0] gap_size,
  input  logic signed [31:0] lost_so_far,
  input  logic [31:0]        received_so_far,
  input  logic [3:0]         bin_hit,
  output int                 mismatch_count,
  output int                 awaited_count
);

  localparam logic [31:0] TOP_BIN = HIST_BINS - 1;
  localparam int          SW      = $clog2(NUM_SENDERS);

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] gap_size;
    logic signed [31:0] lost_so_far;
    logic [31:0]        received_so_far;
    logic [3:0]         bin_hit;
  } frame_result_t;

  logic [7:0]    own_number;
  logic [31:0]   last_count [NUM_SENDERS];
  logic [31:0]   lost_sum [NUM_SENDERS];
  logic [31:0]   in_order_sum [NUM_SENDERS];
  frame_result_t awaited [$];
  frame_result_t oldest;
  int            mismatches = 0;

  function automatic frame_result_t track_frame(input logic [7:0] src,
                                                input logic [31:0] count);
    frame_result_t res;
    logic [SW-1:0] idx;
    logic [31:0]   prev;
    logic [31:0]   gap;
    logic [31:0]   magnitude;
    logic [31:0]   bin;
    res = '0;
    if (src == own_number) begin
      res.status = ST_OWN;
      return res;
    end
    if (src >= NUM_SENDERS) begin
      res.status = ST_BAD;
      return res;
    end
    idx = src[SW-1:0];
    prev = last_count[idx];
    if (prev == 32'd0) prev = count - 32'd1;
    if (count < prev) prev = count - 32'd1;
    gap = count - prev - 32'd1;
    if (gap != 32'd0) begin
      res.status = ST_GAP;
      lost_sum[idx] = lost_sum[idx] + gap;
      magnitude = gap[31] ? (32'd0 - gap) : gap;
      bin = (magnitude > TOP_BIN) ? TOP_BIN : magnitude;
    end else begin
      res.status = ST_IN_ORDER;
      in_order_sum[idx] = in_order_sum[idx] + 32'd1;
      bin = 32'd0;
    end
    last_count[idx] = count;
    res.gap_size = gap;
    res.lost_so_far = lost_sum[idx];
    res.received_so_far = in_order_sum[idx];
    res.bin_hit = bin[3:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      own_number = 8'hFF;
      foreach (last_count[i]) begin
        last_count[i] = '0;
        lost_sum[i] = '0;
        in_order_sum[i] = '0;
      end
      awaited.delete();
    end else begin
      if (cfg_we) own_number = cfg_wdata;
      if (in_valid && in_ready) awaited.push_back(track_frame(sender, frame_count));
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("Result item arrived with no frame header outstanding.");
          mismatches++;
        end else begin
          oldest = awaited.pop_front();
          if (status !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, status);
            mismatches++;
          end
          if (gap_size !== oldest.gap_size) begin
            $error("gap_size: expected %0d, actual %0d", oldest.gap_size, gap_size);
            mismatches++;
          end
          if (lost_so_far !== oldest.lost_so_far) begin
            $error("lost_so_far: expected %0d, actual %0d", oldest.lost_so_far,
                   lost_so_far);
            mismatches++;
          end
          if (received_so_far !== oldest.received_so_far) begin
            $error("received_so_far: expected %0d, actual %0d",
                   oldest.received_so_far, received_so_far);
            mismatches++;
          end
          if (bin_hit !== oldest.bin_hit) begin
            $error("bin_hit: expected %0d, actual %0d", oldest.bin_hit, bin_hit);
            mismatches++;
          end
        end
      end
    end
    mismatch_count <= mismatches;
    awaited_count <= awaited.size();
  end

endmodule

// ===== tb/sequence_gap_loss_monitor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequence_gap_loss_monitor_tb
// Sends directed and then mostly well-formed random frame header streams
// under three idling patterns and several own-number settings, with long
// receiver stalls, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module sequence_gap_loss_monitor_tb;

  localparam int NUM_SENDERS = 8;
  localparam int HIST_BINS   = 16;
  localparam int SW          = $clog2(NUM_SENDERS);
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [7:0]         cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         sender;
  logic [31:0]        frame_count;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic signed [31:0] gap_size;
  logic signed [31:0] lost_so_far;
  logic [31:0]        received_so_far;
  logic [3:0]         bin_hit;

  int          mismatch_count;
  int          awaited_count;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          holds_wanted = 0;
  logic [7:0]  own_setting;
  logic [31:0] stream_last [NUM_SENDERS];

  sequence_gap_loss_monitor #(
    .NUM_SENDERS(NUM_SENDERS),
    .HIST_BINS  (HIST_BINS)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sender         (sender),
    .frame_count    (frame_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .gap_size       (gap_size),
    .lost_so_far    (lost_so_far),
    .received_so_far(received_so_far),
    .bin_hit        (bin_hit)
  );

  sglm_checker #(
    .NUM_SENDERS(NUM_SENDERS),
    .HIST_BINS  (HIST_BINS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sender         (sender),
    .frame_count    (frame_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .gap_size       (gap_size),
    .lost_so_far    (lost_so_far),
    .received_so_far(received_so_far),
    .bin_hit        (bin_hit),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // A requested hold-off keeps the result side stalled so the block backs up.
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_wanted > holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_frame(input logic [7:0] src, input logic [31:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sender <= src;
    frame_count <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (src < NUM_SENDERS && src != own_setting) stream_last[src[SW-1:0]] = count;
  endtask

  task automatic settle_and_configure(input logic [7:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    own_setting = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame();
    int          pick;
    logic [7:0]  src;
    logic [31:0] count;
    pick = $urandom_range(99);
    src = 8'($urandom_range(NUM_SENDERS - 1));
    count = stream_last[src[SW-1:0]] + 32'd1;
    if (pick < 55) begin
      count = stream_last[src[SW-1:0]] + 32'd1;
    end else if (pick < 68) begin
      count = stream_last[src[SW-1:0]] + $urandom_range(20, 2);
    end else if (pick < 73) begin
      count = stream_last[src[SW-1:0]];
    end else if (pick < 78) begin
      count = stream_last[src[SW-1:0]] - $urandom_range(6, 1);
    end else if (pick < 82) begin
      count = $urandom();
    end else if (pick < 86) begin
      count = 32'hFFFF_FFF0 + $urandom_range(15);
    end else if (pick < 90) begin
      count = stream_last[src[SW-1:0]] + $urandom_range(32'h8000_0000);
    end else if (pick < 94) begin
      src = own_setting;
    end else begin
      src = 8'($urandom_range(255, NUM_SENDERS));
    end
    send_frame(src, count);
  endtask

  task automatic run_phase(input int items);
    int done;
    done = 0;
    while (done < items) begin
      random_frame();
      done++;
      if (done == items / 2) holds_wanted <= holds_wanted + 1;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    in_valid = 1'b0;
    sender = 8'd0;
    frame_count = 32'd0;
    own_setting = 8'hFF;
    foreach (stream_last[i]) stream_last[i] = 32'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 6;
    recv_idle_pct <= 59;

    settle_and_configure(8'd3);
    send_frame(8'd3, 32'h1234_5678);
    send_frame(8'd8, 32'hFFFF_FFFF);
    send_frame(8'd255, 32'h0000_0000);
    send_frame(8'd128, 32'h5555_5555);
    send_frame(8'd0, 32'h0000_0000);
    send_frame(8'd0, 32'h0000_0000);
    send_frame(8'd0, 32'h0000_0001);
    send_frame(8'd0, 32'h0000_0001);
    send_frame(8'd0, 32'h0000_0005);
    send_frame(8'd0, 32'h0000_0002);
    send_frame(8'd0, 32'h0000_0003);
    send_frame(8'd0, 32'hFFFF_FFFF);
    send_frame(8'd1, 32'h0000_0001);
    send_frame(8'd1, 32'h8000_0002);
    send_frame(8'd2, 32'h0000_0001);
    send_frame(8'd2, 32'h8000_0001);
    send_frame(8'd2, 32'h8000_0010);
    send_frame(8'd2, 32'h8000_0020);
    send_frame(8'd2, 32'h8000_0031);
    send_frame(8'd7, 32'hFFFF_FFFF);
    send_frame(8'd7, 32'hFFFF_FFFF);
    send_frame(8'd7, 32'h0000_0000);
    send_frame(8'd4, 32'hAAAA_AAAA);
    send_frame(8'd4, 32'hAAAA_AAAB);

    settle_and_configure(8'd255);
    run_phase(440);

    send_idle_pct = 59;
    recv_idle_pct <= 6;
    settle_and_configure(8'd0);
    run_phase(440);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    settle_and_configure(8'($urandom_range(NUM_SENDERS - 2, 1)));
    run_phase(440);

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sglm_pkg.sv
hw/rtl/sglm_ram.sv
hw/rtl/sglm_ctrl.sv
hw/rtl/sglm_dp.sv
hw/rtl/sequence_gap_loss_monitor.sv
tb/sglm_checker.sv
tb/sequence_gap_loss_monitor_tb.sv
